### sv/assert_macros.svh
// Assertion macros used by the parser unit to check its own logic.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define NFCV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true, outside reset.
`define NFCV_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

### sv/nfcv_sir_pkg.sv
package nfcv_sir_pkg;

    // Bytes of one reply frame that are kept; later bytes are ignored.
    localparam int MAX_FRAME_BYTES = 64;
    // The byte count must be able to hold MAX_FRAME_BYTES itself.
    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [4:0]  BLK_SIZE_MASK = 5'h1F;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_CARD = 2'd1;
    localparam logic [1:0] ST_TAG_ERR = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    // Frame state after the current byte has been taken in.
    typedef struct packed {
        logic [IDX_W-1:0] n;
        logic [15:0]      crc;
        logic [15:0]      held;
        logic [7:0]       first;
        logic [7:0]       second;
        logic [63:0]      uid;
        logic [39:0]      opt;
    } frame_snap_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  tag_error_code;
        logic [63:0] uid;
        logic [7:0]  sys_flags;
        logic [7:0]  dsfid;
        logic [7:0]  afi;
        logic [8:0]  num_blocks;
        logic [5:0]  bytes_per_blk;
        logic [7:0]  ic_ref;
        logic        memory_info_valid;
        logic        crc_matched;
    } result_t;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/nfcv_system_info_response_parser_unit.sv
// Parses the reply to an ISO 15693 Get System Information command, one received
// byte per input transfer. Each byte is first captured in an input register;
// from there it updates the frame state (byte count, a running reflected
// CRC-16 over all but the two most recent bytes, and the bytes kept for the
// UID and optional fields), and a byte that ends the frame (last_byte or
// no_reply) also loads one result into the output register. The block
// therefore takes one byte every cycle unless a frame-ending byte is held up,
// and the result register is loaded as the byte that ends its frame leaves
// the input register. The figure of one byte a cycle rests on the single-byte
// CRC update in the next-state logic of the frame state register. Only a
// frame-ending byte can be held up, and only while an earlier result still
// sits in the output register untaken.
`include "assert_macros.svh"

module nfcv_system_info_response_parser_unit
    import nfcv_sir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        last_byte,
    input  logic        no_reply,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  tag_error_code,
    output logic [63:0] uid,
    output logic [7:0]  sys_flags,
    output logic [7:0]  dsfid,
    output logic [7:0]  afi,
    output logic [8:0]  num_blocks,
    output logic [5:0]  bytes_per_blk,
    output logic [7:0]  ic_ref,
    output logic        memory_info_valid,
    output logic        crc_matched
);

    // Input register.
    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        noreply_reg;

    // Result register.
    logic        out_vld_reg;
    result_t     res_reg;

    logic        frame_end;
    logic        advance;
    frame_snap_t snap;
    result_t     res_next;

    assign frame_end = last_reg || noreply_reg;

    // A byte that produces no result never waits for the output side; a
    // frame-ending byte moves on once the result register is free or is being
    // emptied in the same cycle.
    assign advance  = in_vld_reg && (!frame_end || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg    <= rx_byte;
            last_reg    <= last_byte;
            noreply_reg <= no_reply;
        end
    end

    nfcv_sir_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (byte_reg),
        .frame_end (frame_end),
        .snap      (snap)
    );

    nfcv_sir_decode u_decode (
        .snap     (snap),
        .no_reply (noreply_reg),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && frame_end)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_end)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign status            = res_reg.status;
    assign tag_error_code    = res_reg.tag_error_code;
    assign uid               = res_reg.uid;
    assign sys_flags         = res_reg.sys_flags;
    assign dsfid             = res_reg.dsfid;
    assign afi               = res_reg.afi;
    assign num_blocks        = res_reg.num_blocks;
    assign bytes_per_blk     = res_reg.bytes_per_blk;
    assign ic_ref            = res_reg.ic_ref;
    assign memory_info_valid = res_reg.memory_info_valid;
    assign crc_matched       = res_reg.crc_matched;

    // A result still waiting must never be overwritten by the next frame end.
    `NFCV_ASSERT_NEVER(a_no_overwrite, out_vld_reg && !out_ready && advance && frame_end)
    // Decoded reply fields are only ever reported for a good reply.
    `NFCV_ASSERT_IMPL(a_fields_zero, out_valid && (status != ST_OK), (uid == 64'd0) && (sys_flags == 8'd0) && (memory_info_valid == 1'b0))
    // A missing card carries neither an error code nor a trailer match.
    `NFCV_ASSERT_IMPL(a_no_card_clean, out_valid && (status == ST_NO_CARD), (tag_error_code == 8'd0) && (crc_matched == 1'b0))
    // Block geometry reads zero unless the memory flag was decoded.
    `NFCV_ASSERT_IMPL(a_mem_fields, out_valid && !memory_info_valid, (num_blocks == 9'd0) && (bytes_per_blk == 6'd0))

endmodule

### sv/nfcv_sir_frame.sv
module nfcv_sir_frame
    import nfcv_sir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output frame_snap_t snap
);

    frame_snap_t st_reg;
    frame_snap_t st_next;
    frame_snap_t clr;

    assign clr = '{n: '0, crc: CRC_INIT, held: '0, first: '0, second: '0,
                   uid: '0, opt: '0};

    // Take the current byte in, unless the frame has already filled.
    always_comb
    begin
        snap = st_reg;
        if (st_reg.n < IDX_W'(MAX_FRAME_BYTES))
        begin
            if (st_reg.n >= IDX_W'(2))
            begin
                snap.crc = crc_byte(st_reg.crc, st_reg.held[7:0]);
            end
            snap.held = {rx_byte, st_reg.held[15:8]};
            if (st_reg.n == IDX_W'(0))
            begin
                snap.first = rx_byte;
            end
            if (st_reg.n == IDX_W'(1))
            begin
                snap.second = rx_byte;
            end
            for (int k = 0; k < 8; k++)
            begin
                if (st_reg.n == IDX_W'(k + 2))
                begin
                    snap.uid[8*k +: 8] = rx_byte;
                end
            end
            for (int k = 0; k < 5; k++)
            begin
                if (st_reg.n == IDX_W'(k + 10))
                begin
                    snap.opt[8*k +: 8] = rx_byte;
                end
            end
            snap.n = st_reg.n + IDX_W'(1);
        end
    end

    // Every frame end, with or without a reply, returns the frame to its start.
    assign st_next = frame_end ? clr : snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{n: '0, crc: CRC_INIT, held: '0, first: '0, second: '0,
                        uid: '0, opt: '0};
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

endmodule

### sv/nfcv_sir_decode.sv
module nfcv_sir_decode
    import nfcv_sir_pkg::*;
(
    input  frame_snap_t snap,
    input  logic        no_reply,
    output result_t     res
);

    logic             matched;
    logic [IDX_W-1:0] plen;
    logic [7:0]       flags;
    logic [2:0]       idx_afi;
    logic [2:0]       idx_bc;
    logic [2:0]       idx_ic;
    logic [7:0]       bs_raw;

    function automatic logic [7:0] opt_at(input logic [39:0] opt, input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = opt[7:0];
            3'd1:    v = opt[15:8];
            3'd2:    v = opt[23:16];
            3'd3:    v = opt[31:24];
            3'd4:    v = opt[39:32];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    always_comb
    begin
        flags   = snap.second;
        matched = (snap.n >= IDX_W'(3)) && ((~snap.crc) == snap.held);
        plen    = matched ? (snap.n - IDX_W'(2)) : snap.n;
        idx_afi = {2'b00, flags[0]};
        idx_bc  = idx_afi + {2'b00, flags[1]};
        idx_ic  = idx_bc + {1'b0, flags[2], 1'b0};
        bs_raw  = opt_at(snap.opt, idx_bc + 3'd1);

        res = '0;
        if (no_reply || (snap.n < IDX_W'(2)))
        begin
            res.status = ST_NO_CARD;
        end
        else
        begin
            res.crc_matched = matched;
            if (snap.first[0])
            begin
                res.status         = ST_TAG_ERR;
                res.tag_error_code = snap.second;
            end
            else if (plen < IDX_W'(10))
            begin
                res.status = ST_SHORT;
            end
            else
            begin
                res.status     = ST_OK;
                res.uid        = snap.uid;
                res.sys_flags  = flags;
                if (flags[0])
                begin
                    res.dsfid = opt_at(snap.opt, 3'd0);
                end
                if (flags[1])
                begin
                    res.afi = opt_at(snap.opt, idx_afi);
                end
                if (flags[2])
                begin
                    res.num_blocks    = {1'b0, opt_at(snap.opt, idx_bc)} + 9'd1;
                    res.bytes_per_blk = {1'b0, bs_raw[4:0] & BLK_SIZE_MASK} + 6'd1;
                    res.memory_info_valid = 1'b1;
                end
                if (flags[3])
                begin
                    res.ic_ref = opt_at(snap.opt, idx_ic);
                end
            end
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the Get System Information reply parser.
// Reply frames are fed in one byte per input transfer. A scoreboard object
// models the frame state itself (byte count, running CRC, the two held
// trailer bytes and the kept field bytes). At every frame end it queues the
// one result that the block should give. Each output transfer is checked
// field by field against the oldest queued result.
module testbench;
    import nfcv_sir_pkg::*;

    // Roughly how many reply bytes the random part sends before it stops.
    localparam int BYTE_TARGET = 1900;
    // Far beyond the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    // Percentage of cycles in which each side holds back.
    localparam int IDLE_PCT    = 17;

    // The scoreboard keeps its own copy of the frame state and works out the
    // result of each frame as its last byte (or a timeout) is transferred.
    class reply_scoreboard;
        int unsigned kept;
        logic [15:0] crc_acc;
        logic [15:0] trailer;
        logic [7:0]  resp_flags;
        logic [7:0]  info_byte;
        logic [63:0] uid_acc;
        logic [39:0] opt_acc;
        result_t     awaited[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            kept       = 0;
            crc_acc    = CRC_INIT;
            trailer    = '0;
            resp_flags = '0;
            info_byte  = '0;
            uid_acc    = '0;
            opt_acc    = '0;
        endfunction

        // Reflected CRC-16: the register shifts right, least significant bit first.
        function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] acc;
            acc = c;
            for (int i = 0; i < 8; i++) begin
                if (acc[0] ^ b[i])
                    acc = {1'b0, acc[15:1]} ^ CRC_POLY;
                else
                    acc = {1'b0, acc[15:1]};
            end
            return acc;
        endfunction

        // Optional fields sit at raw byte positions 10 to 14. Anything that
        // was never received reads as zero.
        function logic [7:0] opt_at(int unsigned pos);
            if (pos < 10 || pos > 14)
                return 8'h00;
            return opt_acc[8*(pos-10) +: 8];
        endfunction

        function void note_transfer(logic [7:0] b, logic lb, logic nr);
            result_t     r;
            logic [15:0] calc;
            logic [7:0]  raw;
            int unsigned plen;
            int unsigned pos;
            r = '0;
            // A timeout drops whatever was gathered and reports no card.
            if (nr) begin
                r.status = ST_NO_CARD;
                awaited.push_back(r);
                clear_frame();
                return;
            end
            // Bytes past the buffer are ignored. Their last_byte still counts.
            if (kept < MAX_FRAME_BYTES) begin
                if (kept >= 2)
                    crc_acc = crc_update(crc_acc, trailer[7:0]);
                trailer = {b, trailer[15:8]};
                if (kept == 0)
                    resp_flags = b;
                else if (kept == 1)
                    info_byte = b;
                else if (kept <= 9)
                    uid_acc[8*(kept-2) +: 8] = b;
                else if (kept <= 14)
                    opt_acc[8*(kept-10) +: 8] = b;
                kept++;
            end
            if (!lb)
                return;

            if (kept < 2) begin
                r.status = ST_NO_CARD;
                awaited.push_back(r);
                clear_frame();
                return;
            end
            plen = kept;
            calc = ~crc_acc;
            if (kept >= 3 && calc == trailer) begin
                r.crc_matched = 1'b1;
                plen = kept - 2;
            end
            if (resp_flags[0]) begin
                r.status = ST_TAG_ERR;
                r.tag_error_code = info_byte;
            end
            else if (plen < 10) begin
                r.status = ST_SHORT;
            end
            else begin
                r.status = ST_OK;
                r.uid = uid_acc;
                r.sys_flags = info_byte;
                pos = 10;
                if (info_byte[0]) begin
                    r.dsfid = opt_at(pos);
                    pos++;
                end
                if (info_byte[1]) begin
                    r.afi = opt_at(pos);
                    pos++;
                end
                if (info_byte[2]) begin
                    r.num_blocks = {1'b0, opt_at(pos)} + 9'd1;
                    pos++;
                    raw = opt_at(pos);
                    r.bytes_per_blk = {1'b0, raw[4:0] & BLK_SIZE_MASK} + 6'd1;
                    pos++;
                    r.memory_info_valid = 1'b1;
                end
                if (info_byte[3])
                    r.ic_ref = opt_at(pos);
            end
            awaited.push_back(r);
            clear_frame();
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result with no frame end waiting, status %0d",
                         $time, got.status);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare("status", want.status, got.status);
            compare("tag_error_code", want.tag_error_code, got.tag_error_code);
            compare("uid", want.uid, got.uid);
            compare("sys_flags", want.sys_flags, got.sys_flags);
            compare("dsfid", want.dsfid, got.dsfid);
            compare("afi", want.afi, got.afi);
            compare("num_blocks", want.num_blocks, got.num_blocks);
            compare("bytes_per_blk", want.bytes_per_blk, got.bytes_per_blk);
            compare("ic_ref", want.ic_ref, got.ic_ref);
            compare("memory_info_valid", want.memory_info_valid, got.memory_info_valid);
            compare("crc_matched", want.crc_matched, got.crc_matched);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        last_byte;
    logic        no_reply;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  tag_error_code;
    logic [63:0] uid;
    logic [7:0]  sys_flags;
    logic [7:0]  dsfid;
    logic [7:0]  afi;
    logic [8:0]  num_blocks;
    logic [5:0]  bytes_per_blk;
    logic [7:0]  ic_ref;
    logic        memory_info_valid;
    logic        crc_matched;

    reply_scoreboard board;
    logic [7:0]      frame_bytes[$];
    int unsigned     bytes_sent;
    int unsigned     cycle_count;
    // While set, neither side idles, so the block runs at full rate.
    bit              calm;

    nfcv_system_info_response_parser_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .last_byte         (last_byte),
        .no_reply          (no_reply),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .tag_error_code    (tag_error_code),
        .uid               (uid),
        .sys_flags         (sys_flags),
        .dsfid             (dsfid),
        .afi               (afi),
        .num_blocks        (num_blocks),
        .bytes_per_blk     (bytes_per_blk),
        .ic_ref            (ic_ref),
        .memory_info_valid (memory_info_valid),
        .crc_matched       (crc_matched)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Output side. Everything is sampled at the rising edge, before any
    // nonblocking update of that edge lands, so a transfer is seen exactly as
    // the block sees it. The ready for the next edge is random unless calm is set.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{status: status, tag_error_code: tag_error_code,
                                 uid: uid, sys_flags: sys_flags, dsfid: dsfid,
                                 afi: afi, num_blocks: num_blocks,
                                 bytes_per_blk: bytes_per_blk, ic_ref: ic_ref,
                                 memory_info_valid: memory_info_valid,
                                 crc_matched: crc_matched});
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Guard against a hung block. A stuck handshake would otherwise run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[nfcv_system_info_response_parser_unit] ERROR");
            $finish;
        end
    end

    // One input transfer. Valid is lowered only for an idle gap, so that a
    // valid that carries straight on to the next byte is never dropped and
    // raised again within one time step.
    task automatic send_byte(input logic [7:0] b, input logic lb, input logic nr);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        last_byte <= lb;
        no_reply  <= nr;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_transfer(b, lb, nr);
        bytes_sent++;
    endtask

    // Holds the sender back until every queued result has been taken. Valid is
    // lowered before the first wait on the clock, so it never meets a raise.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.awaited.size() != 0);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0);
    endtask

    // Adds a correct trailer: the inverted CRC, low byte first.
    function automatic void append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i])
            c = board.crc_update(c, frame_bytes[i]);
        c = ~c;
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    // Number of optional bytes that the info flags call for.
    function automatic int unsigned opt_len(logic [7:0] f);
        return int'(f[0]) + int'(f[1]) + 2 * int'(f[2]) + int'(f[3]);
    endfunction

    // Response flags, info flags, a random UID and a number of optional bytes.
    function automatic void build_reply(logic [7:0] resp, logic [7:0] flags,
                                        int unsigned opt_count);
        frame_bytes.delete();
        frame_bytes.push_back(resp);
        frame_bytes.push_back(flags);
        repeat (8) frame_bytes.push_back(8'($urandom));
        repeat (opt_count) frame_bytes.push_back(8'($urandom));
    endfunction

    // Most frames are well-formed replies with random content, so that the
    // decode of the optional fields is reached. The rest are damaged replies,
    // tag errors, short or one-byte frames, timeouts and overlong frames.
    task automatic random_frame();
        int unsigned pick;
        int unsigned idx;
        int unsigned len;
        logic [7:0]  flags;
        pick  = $urandom_range(99);
        flags = 8'($urandom);
        if (pick < 55) begin
            // Trailing optional bytes may be missing; the CRC may be absent.
            if ($urandom_range(4) == 0)
                build_reply(8'($urandom) & 8'hFE, flags, $urandom_range(opt_len(flags)));
            else
                build_reply(8'($urandom) & 8'hFE, flags, opt_len(flags));
            if ($urandom_range(9) != 0)
                append_crc();
            send_frame();
        end
        else if (pick < 65) begin
            // A single bit flipped anywhere, trailer included.
            build_reply(8'($urandom) & 8'hFE, flags, opt_len(flags));
            append_crc();
            idx = $urandom_range(frame_bytes.size() - 1);
            frame_bytes[idx] ^= 8'(1 << $urandom_range(7));
            send_frame();
        end
        else if (pick < 75) begin
            // The tag sets its error flag and gives a code in the next byte.
            frame_bytes.delete();
            frame_bytes.push_back(8'($urandom) | 8'h01);
            frame_bytes.push_back(8'($urandom));
            repeat ($urandom_range(12)) frame_bytes.push_back(8'($urandom));
            if ($urandom_range(1))
                append_crc();
            send_frame();
        end
        else if (pick < 87) begin
            // Frames of 1 to 13 random bytes, mostly short, with or without a trailer.
            frame_bytes.delete();
            len = $urandom_range(1, 13);
            repeat (len) frame_bytes.push_back(8'($urandom));
            if ($urandom_range(9) < 7)
                frame_bytes[0] &= 8'hFE;
            if ($urandom_range(1) && len <= 11)
                append_crc();
            send_frame();
        end
        else if (pick < 96) begin
            // A timeout, possibly after part of a frame.
            len = $urandom_range(10);
            repeat (len) send_byte(8'($urandom), 1'b0, 1'b0);
            send_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
        end
        else begin
            // Overlong: the frame end may fall inside or past the buffer.
            build_reply(8'($urandom) & 8'hFE, flags, opt_len(flags));
            len = $urandom_range(60, 80);
            while (frame_bytes.size() < len)
                frame_bytes.push_back(8'($urandom));
            if ($urandom_range(1))
                append_crc();
            send_frame();
        end
    endtask

    initial
    begin
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        last_byte   = 1'b0;
        no_reply    = 1'b0;
        out_ready   = 1'b0;
        calm        = 1'b0;
        bytes_sent  = 0;
        cycle_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // A timeout on its own, with the byte and end mark set but ignored.
        send_byte(8'hFF, 1'b1, 1'b1);
        // A frame of one byte only, which counts as no card.
        send_byte(8'h00, 1'b1, 1'b0);
        // A tag error with the largest code and a good trailer.
        frame_bytes.delete();
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'hFF);
        append_crc();
        send_frame();
        // A full reply with every optional field at its largest value.
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h0F);
        repeat (13) frame_bytes.push_back(8'hFF);
        append_crc();
        send_frame();

        // Let the block empty before the random part starts.
        wait_drained();

        while (bytes_sent < BYTE_TARGET) begin
            calm = (bytes_sent >= 700 && bytes_sent < 1000);
            random_frame();
            if ($urandom_range(29) == 0)
                wait_drained();
        end
        in_valid <= 1'b0;

        while (board.awaited.size() != 0)
            @(posedge clk);
        // Room for any stray result the block might still put out.
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("[nfcv_system_info_response_parser_unit] OK");
        else
            $display("[nfcv_system_info_response_parser_unit] ERROR");
        $finish;
    end

endmodule
